>>> rtl/qconv_pkg.sv
package qconv_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_ZERO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ZERO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MULT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_SHIFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZERO    = 3'd6;

    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_PIXEL  = 2'd2;

    localparam int ROW_POS_W = 12;
    localparam int MAX_HEIGHT = 4096;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [8:0]         table_index;
        logic signed [7:0]  weight_value;
        logic signed [31:0] bias_value;
        logic signed [7:0]  pixel_value;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] out_value;
        logic [5:0]        out_channel;
        logic [10:0]       out_row;
        logic [8:0]        out_col;
        logic              last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_MULT,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       accept;
        logic       acc_load;
        logic       mac_issue;
        logic       mult_en;
        logic       out_load;
        logic [5:0] co;
        logic [2:0] ci;
        logic [1:0] ky;
        logic [1:0] kx;
    } dp_cmd_t;

    typedef struct packed {
        logic trigger;
        logic out_busy;
    } dp_status_t;

endpackage

>>> rtl/quantized_conv3x3_stride2_core.sv
// channel   ports                            direction
// request   s_valid s_ready s_data           in
// result    m_valid m_ready m_data           out
// config    cfg_we cfg_index cfg_wdata       in, write only
//
// load and pixel requests are taken while idle; a pixel that completes an odd
// row and odd column then runs load, mac, drain, mult and emit per output
// channel on the single mac unit
// s_ready stays low from such a pixel until its last result enters the output
// register; each result waiting on m_ready stretches that by the stall
// aresetn resets position, control, m_valid, config; tables, line store unset
module quantized_conv3x3_stride2_core import qconv_pkg::*; #(
    parameter int IN_CHANNELS  = 3,
    parameter int OUT_CHANNELS = 16,
    parameter int MAX_WIDTH    = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    qconv_ctrl #(
        .IN_CHANNELS  (IN_CHANNELS),
        .OUT_CHANNELS (OUT_CHANNELS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qconv_dp #(
        .IN_CHANNELS  (IN_CHANNELS),
        .OUT_CHANNELS (OUT_CHANNELS),
        .MAX_WIDTH    (MAX_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> rtl/qconv_ctrl.sv
module qconv_ctrl import qconv_pkg::*; #(
    parameter int IN_CHANNELS  = 3,
    parameter int OUT_CHANNELS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [5:0] co_reg, co_next;
    logic [2:0] ci_reg, ci_next;
    logic [1:0] ky_reg, ky_next;
    logic [1:0] kx_reg, kx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            co_reg    <= '0;
            ci_reg    <= '0;
            ky_reg    <= '0;
            kx_reg    <= '0;
        end else begin
            state_reg <= state_next;
            co_reg    <= co_next;
            ci_reg    <= ci_next;
            ky_reg    <= ky_next;
            kx_reg    <= kx_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        co_next       = co_reg;
        ci_next       = ci_reg;
        ky_next       = ky_reg;
        kx_next       = kx_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.co        = co_reg;
        cmd.ci        = ci_reg;
        cmd.ky        = ky_reg;
        cmd.kx        = kx_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && status.trigger) begin
                    co_next    = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.acc_load = 1'b1;
                ci_next      = '0;
                ky_next      = '0;
                kx_next      = '0;
                state_next   = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (ci_reg == 3'(IN_CHANNELS - 1)) begin
                    ci_next = '0;
                    if (kx_reg == 2'd2) begin
                        kx_next = '0;
                        if (ky_reg == 2'd2) begin
                            state_next = ST_DRAIN1;
                        end else begin
                            ky_next = ky_reg + 2'd1;
                        end
                    end else begin
                        kx_next = kx_reg + 2'd1;
                    end
                end else begin
                    ci_next = ci_reg + 3'd1;
                end
            end
            ST_DRAIN1: begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mult_en = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    if (co_reg == 6'(OUT_CHANNELS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        co_next    = co_reg + 6'd1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/qconv_dp.sv
module qconv_dp import qconv_pkg::*; #(
    parameter int IN_CHANNELS  = 3,
    parameter int OUT_CHANNELS = 16,
    parameter int MAX_WIDTH    = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              s_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    localparam int ROW_SIZE = MAX_WIDTH * IN_CHANNELS;
    localparam int LS_DEPTH = 3 * ROW_SIZE;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int W_DEPTH  = IN_CHANNELS * 9 * OUT_CHANNELS;
    localparam int W_AW     = $clog2(W_DEPTH);
    localparam int BI_W     = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int CH_W     = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;

    // configuration
    logic [12:0]       img_h_reg;
    logic [10:0]       img_w_reg;
    logic signed [7:0] in_zero_reg;
    logic signed [7:0] w_zero_reg;
    logic signed [31:0] out_mult_reg;
    logic [5:0]        out_shift_reg;
    logic signed [7:0] out_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_h_reg     <= 13'd640;
            img_w_reg     <= 11'd640;
            in_zero_reg   <= '0;
            w_zero_reg    <= '0;
            out_mult_reg  <= 32'sd1;
            out_shift_reg <= '0;
            out_zero_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_IMG_HEIGHT:  img_h_reg     <= cfg_wdata[12:0];
                CFG_IMG_WIDTH:   img_w_reg     <= cfg_wdata[10:0];
                CFG_IN_ZERO:     in_zero_reg   <= cfg_wdata[7:0];
                CFG_WEIGHT_ZERO: w_zero_reg    <= cfg_wdata[7:0];
                CFG_OUT_MULT:    out_mult_reg  <= cfg_wdata[31:0];
                CFG_OUT_SHIFT:   out_shift_reg <= cfg_wdata[5:0];
                CFG_OUT_ZERO:    out_zero_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // effective image size
    logic [12:0] eff_w, eff_h;

    always_comb begin
        if (img_w_reg == '0) begin
            eff_w = 13'd1;
        end else if (13'(img_w_reg) > 13'(MAX_WIDTH)) begin
            eff_w = 13'(MAX_WIDTH);
        end else begin
            eff_w = 13'(img_w_reg);
        end
        if (img_h_reg == '0) begin
            eff_h = 13'd1;
        end else if (img_h_reg > 13'(MAX_HEIGHT)) begin
            eff_h = 13'(MAX_HEIGHT);
        end else begin
            eff_h = img_h_reg;
        end
    end

    // position tracking
    logic [ROW_POS_W-1:0] row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CH_W-1:0]      chan_reg, chan_next;
    logic [1:0]           slot_reg, slot_next;
    logic [ROW_POS_W-1:0] cur_row_reg;
    logic [COL_W-1:0]     cur_col_reg;
    logic [1:0]           cur_slot_reg;

    logic [ROW_POS_W-1:0] r0, r1;
    logic [COL_W-1:0]     c0, c1;
    logic [CH_W-1:0]      ch0;
    logic [1:0]           s0, s1;
    logic [12:0]          r_inc, c_inc;
    logic                 is_pixel;

    assign is_pixel = (s_data.req_type == REQ_PIXEL);

    always_comb begin
        ch0 = s_data.frame_start ? '0 : chan_reg;
        c0  = s_data.frame_start ? '0 : col_reg;
        r0  = s_data.frame_start ? '0 : row_reg;
        s0  = s_data.frame_start ? '0 : slot_reg;
        c1  = c0;
        r1  = r0;
        s1  = s0;
        if (13'(c0) >= eff_w) begin
            c1    = '0;
            r_inc = 13'(r0) + 13'd1;
            s1    = (s0 == 2'd2) ? 2'd0 : s0 + 2'd1;
            if (r_inc >= eff_h) begin
                r1 = '0;
                s1 = '0;
            end else begin
                r1 = r_inc[ROW_POS_W-1:0];
            end
        end else if (13'(r0) >= eff_h) begin
            r1 = '0;
            s1 = '0;
        end
        chan_next = ch0;
        col_next  = c1;
        row_next  = r1;
        slot_next = s1;
        c_inc     = 13'(c1) + 13'd1;
        r_inc     = 13'(r1) + 13'd1;
        if (ch0 == CH_W'(IN_CHANNELS - 1)) begin
            chan_next = '0;
            if (c_inc >= eff_w) begin
                col_next = '0;
                if (r_inc >= eff_h) begin
                    row_next  = '0;
                    slot_next = '0;
                end else begin
                    row_next  = r_inc[ROW_POS_W-1:0];
                    slot_next = (s1 == 2'd2) ? 2'd0 : s1 + 2'd1;
                end
            end else begin
                col_next = c_inc[COL_W-1:0];
            end
        end else begin
            chan_next = ch0 + CH_W'(1);
        end
    end

    assign status.trigger = is_pixel && (ch0 == CH_W'(IN_CHANNELS - 1)) && r1[0] && c1[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            chan_reg <= '0;
            slot_reg <= '0;
        end else if (cmd.accept && is_pixel) begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            chan_reg <= chan_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && is_pixel) begin
            cur_row_reg  <= r1;
            cur_col_reg  <= c1;
            cur_slot_reg <= s1;
        end
    end

    // tables and line store
    logic [7:0]  ls_mem [LS_DEPTH];
    logic [7:0]  w_mem [W_DEPTH];
    logic [31:0] bias_mem [OUT_CHANNELS];
    logic [7:0]  ls_q_reg, w_q_reg;
    logic [LS_AW-1:0] ls_waddr, ls_raddr;
    logic [W_AW-1:0]  w_raddr;
    logic ls_we, w_we, b_we;
    logic [1:0]  rd_slot;
    logic        tap_valid;

    assign ls_we = cmd.accept && is_pixel;
    assign w_we  = cmd.accept && (s_data.req_type == REQ_WEIGHT)
                   && (32'(s_data.table_index) < W_DEPTH);
    assign b_we  = cmd.accept && (s_data.req_type == REQ_BIAS)
                   && (32'(s_data.table_index) < OUT_CHANNELS);
    assign ls_waddr = LS_AW'(32'(s1) * ROW_SIZE + 32'(c1) * IN_CHANNELS + 32'(ch0));

    always_comb begin
        case (cmd.ky)
            2'd2:    rd_slot = cur_slot_reg;
            2'd1:    rd_slot = (cur_slot_reg == 2'd0) ? 2'd2 : cur_slot_reg - 2'd1;
            default: rd_slot = (cur_slot_reg == 2'd0) ? 2'd1 :
                               (cur_slot_reg == 2'd1) ? 2'd2 : 2'd0;
        endcase
        tap_valid = (32'(cur_row_reg) + 32'(cmd.ky) >= 32'd2)
                    && (32'(cur_col_reg) + 32'(cmd.kx) >= 32'd2);
        ls_raddr = tap_valid
                   ? LS_AW'(32'(rd_slot) * ROW_SIZE
                            + (32'(cur_col_reg) + 32'(cmd.kx) - 32'd2) * IN_CHANNELS
                            + 32'(cmd.ci))
                   : '0;
        w_raddr = W_AW'((32'(cmd.ci) * 9 + 32'(cmd.ky) * 3 + 32'(cmd.kx)) * OUT_CHANNELS
                        + 32'(cmd.co));
    end

    always_ff @(posedge aclk) begin
        if (ls_we) begin
            ls_mem[ls_waddr] <= s_data.pixel_value;
        end
        ls_q_reg <= ls_mem[ls_raddr];
    end

    always_ff @(posedge aclk) begin
        if (w_we) begin
            w_mem[W_AW'(s_data.table_index)] <= s_data.weight_value;
        end
        w_q_reg <= w_mem[w_raddr];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            bias_mem[BI_W'(s_data.table_index)] <= s_data.bias_value;
        end
    end

    // multiply-accumulate pipeline
    logic mac_d1_reg, mac_d2_reg, tap_d1_reg;
    logic signed [8:0]  iv, wv;
    logic signed [17:0] prod_reg;
    logic signed [31:0] acc_reg;
    logic signed [63:0] mult_reg;
    logic signed [63:0] shifted;
    logic signed [64:0] q;
    logic signed [7:0]  q_sat;

    assign iv = $signed({ls_q_reg[7], ls_q_reg}) - $signed({in_zero_reg[7], in_zero_reg});
    assign wv = $signed({w_q_reg[7], w_q_reg}) - $signed({w_zero_reg[7], w_zero_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_d1_reg <= 1'b0;
            mac_d2_reg <= 1'b0;
        end else begin
            mac_d1_reg <= cmd.mac_issue;
            mac_d2_reg <= mac_d1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        tap_d1_reg <= tap_valid;
        prod_reg   <= tap_d1_reg ? iv * wv : 18'sd0;
        if (cmd.acc_load) begin
            acc_reg <= bias_mem[BI_W'(cmd.co)];
        end else if (mac_d2_reg) begin
            acc_reg <= acc_reg + {{14{prod_reg[17]}}, prod_reg};
        end
        if (cmd.mult_en) begin
            mult_reg <= acc_reg * out_mult_reg;
        end
    end

    // requantize
    always_comb begin
        shifted = mult_reg >>> out_shift_reg;
        q = {shifted[63], shifted} + {{57{out_zero_reg[7]}}, out_zero_reg};
        if (q < -65'sd128) begin
            q_sat = -8'sd128;
        end else if (q > 65'sd127) begin
            q_sat = 8'sd127;
        end else begin
            q_sat = q[7:0];
        end
    end

    // result register
    logic      m_valid_reg;
    out_item_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.out_value   <= q_sat;
            out_reg.out_channel <= cmd.co;
            out_reg.out_row     <= cur_row_reg[ROW_POS_W-1:1];
            out_reg.out_col     <= 9'(cur_col_reg >> 1);
            out_reg.last_of_run <= (cmd.co == 6'(OUT_CHANNELS - 1));
        end
    end

    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
